// File: hdl/bow_pkg.sv
`default_nettype none

package bow_pkg;

    // Frame geometry
    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MIN_DIM           = 3;

    // Register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTLINE_VALUE = 2'd2;

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 12;
    localparam int PIX_W    = 8;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET   = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET  = 12'd480;
    localparam logic [PIX_W-1:0]    OUTLINE_RESET = 8'd0;

    // Item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_ZERO = 8'd0;
    localparam logic [PIX_W-1:0] PIX_FULL = 8'd255;

    // Pixel classes
    localparam int CLS_W = 2;
    typedef logic [CLS_W-1:0] cls_t;
    localparam cls_t CLS_ZERO  = 2'd0;
    localparam cls_t CLS_FULL  = 2'd1;
    localparam cls_t CLS_OTHER = 2'd2;

    // 3x3 window: position k = 3*column + row, newest column on top
    localparam int WIN_POS    = 9;
    localparam int WIN_CENTER = 4;
    localparam int WIN_W      = WIN_POS * CLS_W;
    localparam int COL_BITS   = 3 * CLS_W;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One word handed from front to back
    typedef struct packed {
        logic shift;    // pixel enters the window
        logic emit;     // a result is produced
        logic border;   // result position lies on the frame border
        logic eof;      // last result of the frame
        cls_t cls_up;
        cls_t cls_mid;
        cls_t cls_cur;
    } bow_word_t;

    function automatic cls_t classify(input logic [PIX_W-1:0] v);
        cls_t c;
        if (v == PIX_ZERO) begin
            c = CLS_ZERO;
        end
        else if (v == PIX_FULL) begin
            c = CLS_FULL;
        end
        else begin
            c = CLS_OTHER;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hdl/bow_queue.sv
`default_nettype none

module bow_queue import bow_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire bow_word_t         wr_word,
    input  wire logic              pop,
    output bow_word_t              head,
    output logic                   empty,
    output logic [QCNT_W-1:0]      count
);

    bow_word_t                slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]        wr_ptr_reg;
    logic [QPTR_W-1:0]        rd_ptr_reg;
    logic [QCNT_W-1:0]        count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= wr_word;
        end
    end

    // pointers and fill count; the front never pushes into a full queue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head  = slots[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

// File: hdl/bow_front.sv
`default_nettype none

module bow_front import bow_pkg::*;
#(
    parameter int MaxWidth = MAX_WIDTH_DEFAULT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 operation,
    input  wire logic [PIX_W-1:0]     pixel,
    output logic                      full,
    input  wire logic [WIDTH_W-1:0]   image_width,
    input  wire logic [HEIGHT_W-1:0]  image_height,
    input  wire logic                 restart,
    input  wire logic [QCNT_W-1:0]    q_count,
    output logic                      q_push,
    output bow_word_t                 q_word
);

    localparam int IDX_W = $clog2(MaxWidth);
    localparam int CNT_W = $clog2(MaxWidth + 1);

    // line store: [3:2] upper row class, [1:0] middle row class
    logic [2*CLS_W-1:0]   line_mem [MaxWidth];
    logic [2*CLS_W-1:0]   rd_data_reg;

    logic [IDX_W-1:0]     col_reg;
    logic [HEIGHT_W-1:0]  row_reg;
    logic [IDX_W-1:0]     ecol_reg;
    logic [HEIGHT_W-1:0]  erow_reg;

    logic                 s1_valid_reg;
    bow_word_t            s1_word_reg;
    logic [IDX_W-1:0]     s1_col_reg;

    logic [CNT_W-1:0]     w_used;
    logic [HEIGHT_W-1:0]  h_used;
    logic [QCNT_W:0]      inflight;
    logic                 accept;
    logic                 drain;
    logic                 pending;
    logic                 col_last;
    logic                 ecol_last;
    logic                 erow_last;
    logic                 pix_emit;
    logic                 do_shift;
    logic                 do_emit;
    logic                 do_wrap;
    bow_word_t            s0_word;

    // clamp the frame size
    always_comb
    begin
        if (32'(image_width) > MaxWidth)
        begin
            w_used = CNT_W'(MaxWidth);
        end
        else if (32'(image_width) < MIN_DIM)
        begin
            w_used = CNT_W'(MIN_DIM);
        end
        else
        begin
            w_used = CNT_W'(image_width);
        end
        h_used = (32'(image_height) < MIN_DIM) ? HEIGHT_W'(MIN_DIM) : image_height;
    end

    // credit check: queue words plus the one in the read stage
    assign inflight = {1'b0, q_count} + (QCNT_W + 1)'(s1_valid_reg);
    assign full     = (inflight >= (QCNT_W + 1)'(QUEUE_DEPTH));
    assign accept   = push && !full;

    // classify the item
    assign drain     = (row_reg >= h_used);
    assign pending   = (erow_reg < h_used);
    assign col_last  = ((CNT_W'(col_reg) + CNT_W'(1)) == w_used);
    assign ecol_last = ((CNT_W'(ecol_reg) + CNT_W'(1)) == w_used);
    assign erow_last = ((erow_reg + HEIGHT_W'(1)) == h_used);
    assign pix_emit  = (row_reg != '0) && !((row_reg == HEIGHT_W'(1)) && (col_reg == '0));

    assign do_shift = accept && !drain && (operation == OP_PIXEL);
    assign do_emit  = accept && (drain ? pending : ((operation == OP_PIXEL) && pix_emit));
    assign do_wrap  = accept && drain && (!pending || (erow_last && ecol_last));

    always_comb
    begin
        s0_word         = '0;
        s0_word.shift   = do_shift;
        s0_word.emit    = do_emit;
        s0_word.border  = (erow_reg == '0) || erow_last || (ecol_reg == '0) || ecol_last;
        s0_word.eof     = erow_last && ecol_last;
        s0_word.cls_up  = CLS_ZERO;
        s0_word.cls_mid = CLS_ZERO;
        s0_word.cls_cur = classify(pixel);
    end

    // frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else if (restart || do_wrap)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            ecol_reg <= '0;
            erow_reg <= '0;
        end
        else
        begin
            if (do_shift)
            begin
                if (col_last)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            if (do_emit)
            begin
                if (ecol_last)
                begin
                    ecol_reg <= '0;
                    erow_reg <= erow_reg + 1'b1;
                end
                else
                begin
                    ecol_reg <= ecol_reg + 1'b1;
                end
            end
        end
    end

    // line store: read at accept, write back in the next cycle
    always_ff @(posedge clk)
    begin
        if (do_shift)
        begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_valid_reg && s1_word_reg.shift)
        begin
            line_mem[s1_col_reg] <= {rd_data_reg[CLS_W-1:0], s1_word_reg.cls_cur};
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= do_shift || do_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_shift || do_emit)
        begin
            s1_word_reg <= s0_word;
            s1_col_reg  <= col_reg;
        end
    end

    // merge line store data into the queue word
    always_comb
    begin
        q_word         = s1_word_reg;
        q_word.cls_up  = rd_data_reg[2*CLS_W-1:CLS_W];
        q_word.cls_mid = rd_data_reg[CLS_W-1:0];
    end

    assign q_push = s1_valid_reg;

endmodule

`default_nettype wire

// File: hdl/bow_back.sv
`default_nettype none

module bow_back import bow_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire bow_word_t         head,
    input  wire logic              q_empty,
    output logic                   q_pop,
    input  wire logic [PIX_W-1:0]  outline_value,
    input  wire logic              pop,
    output logic                   empty,
    output logic [PIX_W-1:0]       out_pixel,
    output logic                   end_of_frame
);

    logic [WIN_W-1:0]  win_reg;
    logic [WIN_W-1:0]  win_next;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              out_eof_reg;
    logic              all_zero;
    logic              all_full;
    logic [PIX_W-1:0]  value;

    // take the head word unless its result has nowhere to go
    assign q_pop = !q_empty && (!head.emit || !out_valid_reg || pop);

    // window shift and neighbour test
    always_comb
    begin
        win_next = head.shift ? {head.cls_cur, head.cls_mid, head.cls_up,
                                 win_reg[WIN_W-1:COL_BITS]}
                              : win_reg;
        all_zero = 1'b1;
        all_full = 1'b1;
        for (int k = 0; k < WIN_POS; k++)
        begin
            if (k != WIN_CENTER)
            begin
                if (win_next[k*CLS_W +: CLS_W] != CLS_ZERO)
                begin
                    all_zero = 1'b0;
                end
                if (win_next[k*CLS_W +: CLS_W] != CLS_FULL)
                begin
                    all_full = 1'b0;
                end
            end
        end
        value = (head.border || all_zero || all_full) ? PIX_FULL : outline_value;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && head.shift)
        begin
            win_reg <= win_next;
        end
        if (q_pop && head.emit)
        begin
            out_pixel_reg <= value;
            out_eof_reg   <= head.eof;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop && head.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign empty        = !out_valid_reg;
    assign out_pixel    = out_pixel_reg;
    assign end_of_frame = out_eof_reg;

endmodule

`default_nettype wire

// File: hdl/binary_outline_window_3x3_unit.sv
// Binary outline filter over a 3x3 window, streaming one pixel per cycle
// while full is low. Input queue side: push/full with operation and pixel.
// An item is taken at an edge where push is high and full is low. Pixel
// items arrive in raster order; flush items drain the results still owed
// once the last pixel of the frame is in (one result per flush).
// Result queue side: empty/pop with out_pixel and end_of_frame. A result
// waits on the ports while empty is low and leaves on pop.
// Each result is 255 when all eight neighbours are 0 or all are 255, or
// when the position lies on the frame border; otherwise outline_value.
// Results trail the pixels by one row plus one pixel.
// A word that gives a result is registered in the read stage as the line
// store is read, then written into the queue, then taken from the queue
// head through the window shift into the output register.
// Throughput: one word per cycle while full is low, set by the line store
// taking one read and one write per cycle and the one-column-per-cycle
// window shift. Receiver stall: a four-word queue between front and back
// absorbs it; full rises when the queue and the read stage together hold
// four words. Reset: counters cleared, registers back to 640x480 and
// outline 0; the line store is not cleared, no reset sweep. Config via
// cfg_valid/cfg_ready (always ready); writing width or height restarts the frame.
`default_nettype none

module binary_outline_window_3x3_unit import bow_pkg::*;
#(
    parameter int MaxWidth = MAX_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic                   operation,
    input  wire logic [PIX_W-1:0]       pixel,
    input  wire logic                   pop,
    output logic                        empty,
    output logic [PIX_W-1:0]            out_pixel,
    output logic                        end_of_frame,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [WIDTH_W-1:0]   width_reg;
    logic [HEIGHT_W-1:0]  height_reg;
    logic [PIX_W-1:0]     outline_reg;
    logic                 cfg_wr;
    logic                 restart;
    logic                 q_push;
    bow_word_t            q_word;
    bow_word_t            q_head;
    logic                 q_empty;
    logic                 q_pop;
    logic [QCNT_W-1:0]    q_count;

    // register file
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign restart   = cfg_wr && ((cfg_index == CFG_IMAGE_WIDTH) ||
                                  (cfg_index == CFG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
            outline_reg <= OUTLINE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg   <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT:  height_reg  <= cfg_data[HEIGHT_W-1:0];
                CFG_OUTLINE_VALUE: outline_reg <= cfg_data[PIX_W-1:0];
                default:           ;
            endcase
        end
    end

    bow_front #(
        .MaxWidth (MaxWidth)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .operation    (operation),
        .pixel        (pixel),
        .full         (full),
        .image_width  (width_reg),
        .image_height (height_reg),
        .restart      (restart),
        .q_count      (q_count),
        .q_push       (q_push),
        .q_word       (q_word)
    );

    bow_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_word (q_word),
        .pop     (q_pop),
        .head    (q_head),
        .empty   (q_empty),
        .count   (q_count)
    );

    bow_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .outline_value (outline_reg),
        .pop           (pop),
        .empty         (empty),
        .out_pixel     (out_pixel),
        .end_of_frame  (end_of_frame)
    );

    // queue plus read stage never exceed the credit limit
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        (({1'b0, q_count} + (QCNT_W + 1)'(q_push)) <= (QCNT_W + 1)'(QUEUE_DEPTH)))
        else $error("front/back queue overrun");

    // a free output register never leaves a queued word waiting
    a_back_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && empty) |-> q_pop)
        else $error("back stalled with free output register");

    // only words that change the window or give a result enter the queue
    a_word_useful: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_word.shift || q_word.emit))
        else $error("idle word entered the queue");

endmodule

`default_nettype wire
